// File: hdl/hbmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbmm_pkg
// Types and constants shared by the hat basis mass matrix entry block.
// ----------------------------------------------------------------------------
package hbmm_pkg;

  localparam int LEVEL_W    = 4;
  localparam int INDEX_W    = 15;
  localparam int MANT_W     = 32;
  localparam int EXP_W      = 8;
  localparam int THIRDS_W   = 5;

  // levels above this are clamped
  localparam int LEVEL_MAX  = 15;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  localparam logic [MANT_W-1:0]   Q_ONE      = 32'h8000_0000;
  localparam logic [EXP_W-1:0]    EXP_SAT    = 8'd255;
  localparam logic [THIRDS_W-1:0] THIRDS_SAT = 5'd31;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [INDEX_W-1:0] index_t;

  // one dimension as it arrives
  typedef struct packed {
    level_t level_a;
    index_t index_a;
    level_t level_b;
    index_t index_b;
    logic   last_dim;
  } item_t;

  // per-dimension factor handed from the factor stage to the accumulator
  typedef struct packed {
    logic              zero;    // dimension forces the entry to zero
    logic              same;    // identical functions: one more 2/3 factor
    level_t            level;   // finer level, added to the exponent
    logic [MANT_W-1:0] factor;  // Q1.31 overlap factor
    logic              last;
  } factor_t;

endpackage

// File: hdl/hat_basis_mass_matrix_entry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hat_basis_mass_matrix_entry
// L2 inner product of two hierarchical hat functions, one dimension per beat.
// ----------------------------------------------------------------------------
// Each input beat carries the level and index of both hat functions in one
// dimension; tlast marks the final dimension, on which one result beat leaves
// and the running product restarts. The entry equals
// mantissa * 2^-31 * 2^-exponent * (2/3)^thirds, or exactly zero when tuser
// is set. The block takes one dimension per clock: a beat passes the factor
// register (overlap test and Q1.31 factor) and then the accumulator (one
// 32x32 multiply into the running product), which on a last beat loads the
// output register. Only a last beat waits on a full output register, and so
// stalls the input; other beats keep flowing while a result is pending.
// ----------------------------------------------------------------------------
module hat_basis_mass_matrix_entry (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // level_a[3:0], index_a[18:4], level_b[22:19], index_b[37:23], zero fill
  input  logic [hbmm_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic        s_tlast,   // last_dim
  output logic        m_tvalid,
  input  logic        m_tready,
  // entry_mantissa[31:0], entry_exponent[39:32], thirds_count[44:40], zero fill
  output logic [hbmm_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic        m_tuser    // entry_zero
);
  import hbmm_pkg::*;

  item_t               item;
  factor_t             fac;
  logic                fac_valid;
  logic                fac_take;
  logic                out_zero;
  logic [MANT_W-1:0]   out_mantissa;
  logic [EXP_W-1:0]    out_exponent;
  logic [THIRDS_W-1:0] out_thirds;

  // unpack the input beat
  assign item.level_a  = s_tdata[3:0];
  assign item.index_a  = s_tdata[18:4];
  assign item.level_b  = s_tdata[22:19];
  assign item.index_b  = s_tdata[37:23];
  assign item.last_dim = s_tlast;

  hbmm_factor u_factor (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (item),
    .fac_valid (fac_valid),
    .fac_take  (fac_take),
    .fac       (fac)
  );

  hbmm_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .fac_valid    (fac_valid),
    .fac_take     (fac_take),
    .fac          (fac),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_zero     (out_zero),
    .out_mantissa (out_mantissa),
    .out_exponent (out_exponent),
    .out_thirds   (out_thirds)
  );

  // pack the result beat
  assign m_tuser = out_zero;
  assign m_tdata = {3'b000, out_thirds, out_exponent, out_mantissa};

endmodule

// File: hdl/hbmm_factor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbmm_factor
// Computes the overlap factor of one dimension and registers it.
// ----------------------------------------------------------------------------
module hbmm_factor (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  hbmm_pkg::item_t in_item,
  output logic            fac_valid,
  input  logic            fac_take,
  output hbmm_pkg::factor_t fac
);
  import hbmm_pkg::*;

  level_t            la;
  level_t            lb;
  level_t            lf;
  level_t            shift;
  index_t            xf;
  index_t            xc;
  logic signed [31:0] m;
  logic [31:0]       am;
  logic [31:0]       span;
  logic [31:0]       coarse_pos;
  logic [4:0]        q_shift;
  factor_t           fac_next;

  assign in_ready = !fac_valid || fac_take;

  // factor of one dimension
  always_comb begin
    la = (in_item.level_a > level_t'(LEVEL_MAX)) ? level_t'(LEVEL_MAX) : in_item.level_a;
    lb = (in_item.level_b > level_t'(LEVEL_MAX)) ? level_t'(LEVEL_MAX) : in_item.level_b;
    if (la > lb) begin
      lf    = la;
      shift = la - lb;
      xf    = in_item.index_a;
      xc    = in_item.index_b;
    end else begin
      lf    = lb;
      shift = lb - la;
      xf    = in_item.index_b;
      xc    = in_item.index_a;
    end
    // offset of the fine centre from the coarse centre, on the fine grid
    coarse_pos = 32'(xc) << shift;
    m          = $signed(32'(xf)) - $signed(coarse_pos);
    am         = m[31] ? 32'(-m) : 32'(m);
    span       = 32'd1 << shift;
    q_shift    = 5'd31 - {1'b0, shift};

    fac_next.last  = in_item.last_dim;
    fac_next.level = lf;
    if (la == lb) begin
      fac_next.same   = (in_item.index_a == in_item.index_b);
      fac_next.zero   = (in_item.index_a != in_item.index_b);
      fac_next.factor = Q_ONE;
    end else begin
      fac_next.same   = 1'b0;
      // touching at an end counts as disjoint
      fac_next.zero   = (am > span);
      fac_next.factor = (am >= span) ? '0 : ((span - am) << q_shift);
    end
  end

  // factor register
  always_ff @(posedge clk) begin
    if (rst) begin
      fac_valid <= 1'b0;
    end else if (in_ready) begin
      fac_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fac <= fac_next;
    end
  end

endmodule

// File: hdl/hbmm_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbmm_accum
// Multiplies factors into the running entry and emits it on the last dimension.
// ----------------------------------------------------------------------------
module hbmm_accum (
  input  logic              clk,
  input  logic              rst,
  input  logic              fac_valid,
  output logic              fac_take,
  input  hbmm_pkg::factor_t fac,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_zero,
  output logic [hbmm_pkg::MANT_W-1:0]   out_mantissa,
  output logic [hbmm_pkg::EXP_W-1:0]    out_exponent,
  output logic [hbmm_pkg::THIRDS_W-1:0] out_thirds
);
  import hbmm_pkg::*;

  logic [MANT_W-1:0]   run_mantissa;
  logic [EXP_W-1:0]    run_exponent;
  logic [THIRDS_W-1:0] run_thirds;
  logic                run_zero;

  logic [MANT_W-1:0]   run_mantissa_next;
  logic [EXP_W-1:0]    run_exponent_next;
  logic [THIRDS_W-1:0] run_thirds_next;
  logic                run_zero_next;
  logic [63:0]         product;
  logic [EXP_W:0]      exp_sum;
  logic                emit;

  // a non-last beat never waits; a last one waits for the output register
  assign fac_take = fac_valid && (!fac.last || !out_valid || out_ready);
  assign emit     = fac_take && fac.last;

  // fold one dimension into the running entry
  always_comb begin
    product           = 64'(run_mantissa) * 64'(fac.factor);
    exp_sum           = {1'b0, run_exponent} + (EXP_W+1)'(fac.level);
    run_mantissa_next = run_mantissa;
    run_exponent_next = run_exponent;
    run_thirds_next   = run_thirds;
    run_zero_next     = run_zero;
    if (!run_zero) begin
      if (fac.zero) begin
        run_zero_next = 1'b1;
      end else begin
        run_mantissa_next = product[62:31];
        run_exponent_next = (exp_sum > (EXP_W+1)'(EXP_SAT)) ? EXP_SAT : exp_sum[EXP_W-1:0];
        if (fac.same && (run_thirds < THIRDS_SAT)) begin
          run_thirds_next = run_thirds + THIRDS_W'(1);
        end
      end
    end
  end

  // running entry
  always_ff @(posedge clk) begin
    if (rst) begin
      run_mantissa <= Q_ONE;
      run_exponent <= '0;
      run_thirds   <= '0;
      run_zero     <= 1'b0;
    end else if (emit) begin
      run_mantissa <= Q_ONE;
      run_exponent <= '0;
      run_thirds   <= '0;
      run_zero     <= 1'b0;
    end else if (fac_take) begin
      run_mantissa <= run_mantissa_next;
      run_exponent <= run_exponent_next;
      run_thirds   <= run_thirds_next;
      run_zero     <= run_zero_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_zero     <= run_zero_next;
      out_mantissa <= run_zero_next ? '0 : run_mantissa_next;
      out_exponent <= run_zero_next ? '0 : run_exponent_next;
      out_thirds   <= run_zero_next ? '0 : run_thirds_next;
    end
  end

endmodule

// File: test/hbmm_entry_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbmm_entry_checker
// Watches both streams of the mass matrix entry block and checks each result.
// ----------------------------------------------------------------------------
// Every accepted input beat is folded into a running per-dimension product
// kept here (overlap test, exact Q1.31 factor, exponent and 2/3 counts). On
// a last beat the predicted entry is queued. Every accepted result beat is
// compared field by field against the oldest queued entry.
// ----------------------------------------------------------------------------
module hbmm_entry_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [hbmm_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           s_tlast,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [hbmm_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           m_tuser,
  output int                             errors,
  output int                             pending
);

  import hbmm_pkg::*;

  typedef struct packed {
    logic                zero;
    logic [MANT_W-1:0]   mant;
    logic [EXP_W-1:0]    expo;
    logic [THIRDS_W-1:0] thirds;
  } entry_t;

  entry_t entries_due[$];

  // running product of the entry being assembled
  logic [MANT_W-1:0]   prod_mant;
  logic [EXP_W-1:0]    prod_exp;
  logic [THIRDS_W-1:0] prod_thirds;
  logic                prod_zero;

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin : watch
    entry_t want;
    level_t la, lb, lf, lc;
    longint ia, ib, xf, xc, m, mag, span, fq, lo, hi, lo_b, hi_b;
    int     top, sh, e;
    if (rst) begin
      prod_mant   = Q_ONE;
      prod_exp    = '0;
      prod_thirds = '0;
      prod_zero   = 1'b0;
      entries_due.delete();
    end else begin
      // result side
      if (m_tvalid && m_tready) begin
        if (entries_due.size() == 0) begin
          $error("result beat with no entry pending: tuser=%0b tdata=%h", m_tuser, m_tdata);
          errors++;
        end else begin
          want = entries_due.pop_front();
          if (m_tuser !== want.zero) begin
            $error("entry_zero: expected %0b, got %0b", want.zero, m_tuser);
            errors++;
          end
          if (m_tdata[31:0] !== want.mant) begin
            $error("entry_mantissa: expected %h, got %h", want.mant, m_tdata[31:0]);
            errors++;
          end
          if (m_tdata[39:32] !== want.expo) begin
            $error("entry_exponent: expected %0d, got %0d", want.expo, m_tdata[39:32]);
            errors++;
          end
          if (m_tdata[44:40] !== want.thirds) begin
            $error("thirds_count: expected %0d, got %0d", want.thirds, m_tdata[44:40]);
            errors++;
          end
        end
      end

      // input side: fold one dimension into the running product
      if (s_tvalid && s_tready) begin
        la = s_tdata[3:0];
        ia = longint'(s_tdata[18:4]);
        lb = s_tdata[22:19];
        ib = longint'(s_tdata[37:23]);
        if (la > LEVEL_MAX) la = level_t'(LEVEL_MAX);
        if (lb > LEVEL_MAX) lb = level_t'(LEVEL_MAX);
        if (!prod_zero) begin
          if (la == lb) begin
            // identical hats give 2/3 * 2^-l, otherwise no overlap
            if (ia == ib) begin
              e = int'(prod_exp) + int'(la);
              prod_exp = (e > int'(EXP_SAT)) ? EXP_SAT : e[EXP_W-1:0];
              if (prod_thirds < THIRDS_SAT) prod_thirds = prod_thirds + THIRDS_W'(1);
            end else begin
              prod_zero = 1'b1;
            end
          end else begin
            // supports on the grid of the finer level
            top  = (la > lb) ? int'(la) : int'(lb);
            lo   = (ia - 1) * (longint'(1) << (top - la));
            hi   = (ia + 1) * (longint'(1) << (top - la));
            lo_b = (ib - 1) * (longint'(1) << (top - lb));
            hi_b = (ib + 1) * (longint'(1) << (top - lb));
            if (lo_b > lo) lo = lo_b;
            if (hi_b < hi) hi = hi_b;
            if (lo >= hi) begin
              prod_zero = 1'b1;
            end else begin
              if (la > lb) begin
                lf = la; lc = lb; xf = ia; xc = ib;
              end else begin
                lf = lb; lc = la; xf = ib; xc = ia;
              end
              sh   = int'(lf) - int'(lc);
              span = longint'(1) << sh;
              m    = xf - xc * span;
              mag  = (m < 0) ? -m : m;
              fq   = (mag >= span) ? 0 : ((span - mag) << (31 - sh));
              prod_mant = MANT_W'((longint'(prod_mant) * fq) >> 31);
              e = int'(prod_exp) + int'(lf);
              prod_exp = (e > int'(EXP_SAT)) ? EXP_SAT : e[EXP_W-1:0];
            end
          end
        end
        if (s_tlast) begin
          if (prod_zero) want = '{zero: 1'b1, mant: '0, expo: '0, thirds: '0};
          else want = '{zero: 1'b0, mant: prod_mant, expo: prod_exp, thirds: prod_thirds};
          entries_due.push_back(want);
          prod_mant   = Q_ONE;
          prod_exp    = '0;
          prod_thirds = '0;
          prod_zero   = 1'b0;
        end
      end
    end
    pending = entries_due.size();
  end

endmodule

// File: test/hat_basis_mass_matrix_entry_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hat_basis_mass_matrix_entry_test
// Stimulus and verdict for the hat basis mass matrix entry block.
// ----------------------------------------------------------------------------
// Drives a directed set of dimensions (identical hats, same level apart,
// touching supports, a centre on a support edge, shared centres, level zero,
// index extremes, beats after a zero), then random entries of mostly nested
// hats with some long runs that saturate the counters. Sender and receiver
// idle at random in two phases and not at all in a third; one long receiver
// hold-off backs up the block. Checking is done by hbmm_entry_checker.
// ----------------------------------------------------------------------------
module hat_basis_mass_matrix_entry_test;

  import hbmm_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 10;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  s_tlast  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  int errors;
  int pending;
  int dims_sent   = 0;
  int send_idle   = 0;
  int recv_idle   = 0;
  int hold_tag    = 0;
  int hold_seen   = 0;
  int hold_cnt    = 0;
  int stall_count = 0;

  always #1 clk = ~clk;

  hat_basis_mass_matrix_entry dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  hbmm_entry_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending)
  );

  // result side: random ready, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_seen != hold_tag) begin
      hold_seen <= hold_tag;
      hold_cnt  <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog: cycles in which no beat moves on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // offer one dimension and wait for its beat to be taken
  task automatic send_dim(input level_t la, input index_t ia, input level_t lb,
                          input index_t ib, input logic last);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, ib, lb, ia, la};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    dims_sent++;
  endtask

  // one random dimension; long runs use identical hats to saturate counters
  task automatic send_random_dim(input logic last, input bit long_run);
    level_t la, lb, lf, lc;
    index_t ia, ib;
    int     roll, sh, span, xc, m, xf;
    roll = $urandom_range(99);
    if (long_run || roll < 20) begin
      la = long_run ? level_t'($urandom_range(8, 15)) : level_t'($urandom_range(0, 15));
      ia = index_t'($urandom);
      lb = la;
      ib = ia;
    end else if (roll < 75) begin
      // nested hats, offsets around the coarse support edge now and then
      lc   = level_t'($urandom_range(0, 14));
      lf   = level_t'($urandom_range(int'(lc) + 1, 15));
      sh   = int'(lf) - int'(lc);
      span = 1 << sh;
      // the widest coarse hat only fits at index zero
      xc   = (span > 32765) ? 0 : int'($urandom_range(0, (32767 - span - 2) >> sh));
      case ($urandom_range(3))
        0: m = 0;
        1: m = span - 1 + $urandom_range(0, 3);
        default: m = $urandom_range(0, span + 2);
      endcase
      if ($urandom_range(1) == 1) m = -m;
      xf = xc * span + m;
      if (xf < 0) xf = -xf;
      if ($urandom_range(1) == 1) begin
        la = lf; ia = index_t'(xf); lb = lc; ib = index_t'(xc);
      end else begin
        la = lc; ia = index_t'(xc); lb = lf; ib = index_t'(xf);
      end
    end else if (roll < 85) begin
      // same level, different index
      la = level_t'($urandom_range(0, 15));
      lb = la;
      ia = index_t'($urandom);
      ib = ia ^ index_t'($urandom_range(1, 32767));
    end else begin
      la = level_t'($urandom);
      ia = index_t'($urandom);
      lb = level_t'($urandom);
      ib = index_t'($urandom);
    end
    send_dim(la, ia, lb, ib, last);
  endtask

  task automatic send_random_entry();
    int  roll, dims;
    bit  long_run;
    roll     = $urandom_range(99);
    long_run = (roll < 3);
    if (long_run) dims = $urandom_range(30, 40);
    else if (roll < 15) dims = $urandom_range(5, 20);
    else dims = $urandom_range(1, 4);
    for (int d = 0; d < dims; d++) send_random_dim(d == dims - 1, long_run);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_idle = 23;
    recv_idle <= 55;

    // directed: identical, same level apart, touching, centre on the edge, same centre
    send_dim(4'd1, 15'd1, 4'd1, 15'd1, 1'b1);
    send_dim(4'd2, 15'd1, 4'd2, 15'd3, 1'b1);
    send_dim(4'd1, 15'd1, 4'd3, 15'd9, 1'b1);
    send_dim(4'd1, 15'd1, 4'd3, 15'd8, 1'b1);
    send_dim(4'd4, 15'd8, 4'd1, 15'd1, 1'b1);
    // level zero, both alone and against the finest level
    send_dim(4'd0, 15'd0, 4'd0, 15'd0, 1'b1);
    send_dim(4'd0, 15'd0, 4'd15, 15'd5, 1'b1);
    send_dim(4'd0, 15'd1, 4'd15, 15'd32767, 1'b1);
    // index and level extremes
    send_dim(4'd15, 15'd32767, 4'd15, 15'd32767, 1'b1);
    send_dim(4'd15, 15'd0, 4'd14, 15'd0, 1'b1);
    send_dim(4'd14, 15'd16383, 4'd15, 15'd32767, 1'b1);
    // beats after a zero are swallowed until the last one
    send_dim(4'd3, 15'd1, 4'd3, 15'd5, 1'b0);
    send_dim(4'd1, 15'd1, 4'd2, 15'd1, 1'b0);
    send_dim(4'd5, 15'd7, 4'd5, 15'd7, 1'b1);
    // multi-dimension product of nested and identical factors
    send_dim(4'd1, 15'd1, 4'd3, 15'd3, 1'b0);
    send_dim(4'd2, 15'd3, 4'd5, 15'd21, 1'b0);
    send_dim(4'd6, 15'd33, 4'd6, 15'd33, 1'b0);
    send_dim(4'd7, 15'd1, 4'd9, 15'd2, 1'b1);

    // back up the block with a long receiver hold-off
    hold_tag <= hold_tag + 1;
    while (dims_sent < 600) send_random_entry();

    send_idle = 55;
    recv_idle <= 23;
    while (dims_sent < 1200) send_random_entry();

    send_idle = 0;
    recv_idle <= 0;
    while (dims_sent < 1750) send_random_entry();
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/hbmm_pkg.sv
hdl/hbmm_factor.sv
hdl/hbmm_accum.sv
hdl/hat_basis_mass_matrix_entry.sv
test/hbmm_entry_checker.sv
test/hat_basis_mass_matrix_entry_test.sv
